>>> sv/tdcd_pkg.sv
// Shared types and constants for the two-dimensional chained DMA channel.
// Holds the item structs, the channel state record and the code constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdcd_pkg;

    // Input item commands.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_WORD  = 2'd2;

    // Bus register indexes.
    localparam logic [2:0] REG_CONFIG = 3'd0;
    localparam logic [2:0] REG_STRIDE = 3'd1;
    localparam logic [2:0] REG_COUNT  = 3'd2;
    localparam logic [2:0] REG_SRC    = 3'd3;
    localparam logic [2:0] REG_DST    = 3'd4;

    // Status codes reported on chan_status.
    localparam logic [3:0] STAT_IDLE   = 4'd0;
    localparam logic [3:0] STAT_ACTIVE = 4'd5;
    localparam logic [3:0] STAT_SLAVE  = 4'd6;
    localparam logic [3:0] STAT_ERROR  = 4'd13;

    // Config word bit positions.
    localparam int CFG_DMAEN     = 0;
    localparam int CFG_MASTER    = 1;
    localparam int CFG_CHAIN     = 2;
    localparam int CFG_STARTUP   = 3;
    localparam int CFG_IRQEN     = 4;
    localparam int CFG_MSGMODE   = 10;
    localparam int CFG_SRC_INNER = 12;
    localparam int CFG_DST_INNER = 13;
    localparam int CFG_SRC_OUTER = 14;
    localparam int CFG_DST_OUTER = 15;

    // Index of the last descriptor word (destination pointer).
    localparam logic [2:0] DESC_LAST = 3'd5;

    // Channel state, one-hot.
    typedef enum logic [3:0] {
        CH_IDLE   = 4'b0001,
        CH_ACTIVE = 4'b0010,
        CH_SLAVE  = 4'b0100,
        CH_ERROR  = 4'b1000
    } t_chan;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  reg_index;
        logic [31:0] data_word;
        logic        fetch_fault;
    } t_in_item;

    typedef struct packed {
        logic        xfer_valid;
        logic [31:0] xfer_src;
        logic [31:0] xfer_dst;
        logic [3:0]  xfer_bytes;
        logic        fetch_valid;
        logic [15:0] fetch_addr;
        logic        local_irq;
        logic        msg_valid;
        logic [11:0] msg_core;
        logic [3:0]  chan_status;
    } t_out_item;

    // Architectural channel state carried from item to item.
    typedef struct packed {
        t_chan       chan;
        logic [31:0] cfg_word;
        logic [31:0] live_stride;
        logic [15:0] inner_left;
        logic [15:0] outer_left;
        logic [31:0] src_ptr;
        logic [31:0] dst_ptr;
        logic [31:0] desc_istride;
        logic [31:0] desc_ostride;
        logic [15:0] inner_reload;
        logic        fetch_busy;
        logic [2:0]  fetch_word_index;
    } t_state;

    // Channel state after reset: everything cleared, channel idle.
    function automatic t_state reset_state();
        t_state s;
        s      = '0;
        s.chan = CH_IDLE;
        return s;
    endfunction

    // Map the one-hot channel state to its status code.
    function automatic logic [3:0] status_code(input t_chan ch);
        logic [3:0] code;
        unique case (ch)
            CH_IDLE:   code = STAT_IDLE;
            CH_ACTIVE: code = STAT_ACTIVE;
            CH_SLAVE:  code = STAT_SLAVE;
            CH_ERROR:  code = STAT_ERROR;
            default:   code = STAT_ERROR;
        endcase
        return code;
    endfunction

    // Sign-extended 16-bit stride, optionally moved to the upper half.
    function automatic logic [31:0] stride_step(input logic [15:0] s, input logic shift);
        logic [31:0] step;
        if (shift) begin
            step = {s, 16'h0000};
        end else begin
            step = {{16{s[15]}}, s};
        end
        return step;
    endfunction

endpackage

`default_nettype wire

>>> sv/tdcd_in_stage.sv
// Input register stage of the DMA channel: holds one accepted item.
// Uses tdcd_pkg for the input item struct.
`timescale 1ns / 1ps
`default_nettype none

module tdcd_in_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire tdcd_pkg::t_in_item i_item,
    input  wire logic               i_take,
    output logic                    o_valid,
    output tdcd_pkg::t_in_item      o_item
);

    logic               r_valid;
    tdcd_pkg::t_in_item r_item;
    logic               w_load;

    // A held item blocks new input until the execute stage takes it.
    assign o_stall = r_valid && !i_take;
    assign w_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

>>> sv/tdcd_exec.sv
// Execute logic of the DMA channel: next channel state and the result item
// for one input item. Uses tdcd_pkg for structs, codes and helpers.
`timescale 1ns / 1ps
`default_nettype none

module tdcd_exec (
    input  wire tdcd_pkg::t_in_item i_item,
    input  wire tdcd_pkg::t_state   i_state,
    output tdcd_pkg::t_state        o_state,
    output tdcd_pkg::t_out_item     o_result
);

    tdcd_pkg::t_state    n_st;
    tdcd_pkg::t_out_item n_res;
    logic [15:0]         w_next_ptr;
    logic [15:0]         w_inner_dec;
    logic [31:0]         w_step_stride;
    logic                w_shift_src;
    logic                w_shift_dst;
    logic                w_run;

    assign w_next_ptr  = i_state.cfg_word[31:16];
    assign w_inner_dec = i_state.inner_left - 16'd1;
    assign w_run       = i_state.chan == tdcd_pkg::CH_ACTIVE
                      || i_state.chan == tdcd_pkg::CH_SLAVE;

    // Stride and shift selection for the address step after a copy.
    always_comb begin
        if (w_inner_dec != 16'd0) begin
            w_step_stride = i_state.desc_istride;
            w_shift_src   = i_state.cfg_word[tdcd_pkg::CFG_SRC_INNER];
            w_shift_dst   = i_state.cfg_word[tdcd_pkg::CFG_DST_INNER];
        end else begin
            w_step_stride = i_state.desc_ostride;
            w_shift_src   = i_state.cfg_word[tdcd_pkg::CFG_SRC_OUTER];
            w_shift_dst   = i_state.cfg_word[tdcd_pkg::CFG_DST_OUTER];
        end
    end

    // Main item decode.
    always_comb begin
        n_st  = i_state;
        n_res = '0;
        unique case (i_item.cmd)
            tdcd_pkg::CMD_WRITE: begin
                unique case (i_item.reg_index)
                    tdcd_pkg::REG_CONFIG: begin
                        if (i_state.chan != tdcd_pkg::CH_IDLE) begin
                            n_st.chan             = tdcd_pkg::CH_ERROR;
                            n_st.fetch_busy       = 1'b0;
                            n_st.fetch_word_index = '0;
                        end else begin
                            n_st.cfg_word = i_item.data_word;
                            if (i_item.data_word[tdcd_pkg::CFG_DMAEN]
                                || i_item.data_word[tdcd_pkg::CFG_STARTUP]) begin
                                n_st.chan = tdcd_pkg::CH_ACTIVE;
                            end
                        end
                    end
                    tdcd_pkg::REG_STRIDE: n_st.live_stride = i_item.data_word;
                    tdcd_pkg::REG_COUNT: begin
                        n_st.inner_left = i_item.data_word[15:0];
                        n_st.outer_left = i_item.data_word[31:16];
                    end
                    tdcd_pkg::REG_SRC: n_st.src_ptr = i_item.data_word;
                    tdcd_pkg::REG_DST: n_st.dst_ptr = i_item.data_word;
                    // Auto words and status are not kept; writes have no effect.
                    default: ;
                endcase
            end
            tdcd_pkg::CMD_TICK: begin
                if (!i_state.fetch_busy && w_run) begin
                    priority if (!i_state.cfg_word[tdcd_pkg::CFG_DMAEN]
                                 && !i_state.cfg_word[tdcd_pkg::CFG_STARTUP]) begin
                        n_st.chan = tdcd_pkg::CH_ERROR;
                    end else if (i_state.cfg_word[tdcd_pkg::CFG_STARTUP]) begin
                        // Startup descriptor fetch.
                        if (w_next_ptr[2:0] != 3'd0) begin
                            n_st.chan = tdcd_pkg::CH_ERROR;
                        end else begin
                            n_st.fetch_busy       = 1'b1;
                            n_st.fetch_word_index = '0;
                            n_res.fetch_valid     = 1'b1;
                            n_res.fetch_addr      = w_next_ptr;
                        end
                    end else if (!i_state.cfg_word[tdcd_pkg::CFG_MASTER]
                                 || i_state.chan != tdcd_pkg::CH_ACTIVE) begin
                        n_st.chan = tdcd_pkg::CH_ERROR;
                    end else if (i_state.outer_left == 16'd0) begin
                        // Transfer done: interrupts, then stop or chain.
                        n_res.local_irq = i_state.cfg_word[tdcd_pkg::CFG_IRQEN];
                        if (i_state.cfg_word[tdcd_pkg::CFG_MSGMODE]
                            && i_state.dst_ptr[31:20] != 12'd0) begin
                            n_res.msg_valid = 1'b1;
                            n_res.msg_core  = i_state.dst_ptr[31:20];
                        end
                        if (!i_state.cfg_word[tdcd_pkg::CFG_CHAIN]) begin
                            n_st.chan = tdcd_pkg::CH_IDLE;
                        end else if (w_next_ptr[2:0] != 3'd0) begin
                            n_st.chan = tdcd_pkg::CH_ERROR;
                        end else begin
                            n_st.fetch_busy       = 1'b1;
                            n_st.fetch_word_index = '0;
                            n_res.fetch_valid     = 1'b1;
                            n_res.fetch_addr      = w_next_ptr;
                        end
                    end else if (i_state.inner_left == 16'd0) begin
                        n_st.chan = tdcd_pkg::CH_ERROR;
                    end else begin
                        // Element copy and address step.
                        n_res.xfer_valid = 1'b1;
                        n_res.xfer_src   = i_state.src_ptr;
                        n_res.xfer_dst   = i_state.dst_ptr;
                        n_res.xfer_bytes = 4'd1 << i_state.cfg_word[6:5];
                        if (w_inner_dec != 16'd0) begin
                            n_st.inner_left = w_inner_dec;
                        end else begin
                            n_st.outer_left = i_state.outer_left - 16'd1;
                            n_st.inner_left = i_state.inner_reload;
                        end
                        n_st.live_stride = w_step_stride;
                        n_st.src_ptr = i_state.src_ptr
                                     + tdcd_pkg::stride_step(w_step_stride[15:0], w_shift_src);
                        n_st.dst_ptr = i_state.dst_ptr
                                     + tdcd_pkg::stride_step(w_step_stride[31:16], w_shift_dst);
                    end
                end
            end
            tdcd_pkg::CMD_WORD: begin
                if (i_state.fetch_busy) begin
                    if (i_item.fetch_fault) begin
                        n_st.chan             = tdcd_pkg::CH_ERROR;
                        n_st.fetch_busy       = 1'b0;
                        n_st.fetch_word_index = '0;
                    end else begin
                        unique case (i_state.fetch_word_index)
                            3'd0: n_st.cfg_word = i_item.data_word;
                            3'd1: begin
                                n_st.desc_istride = i_item.data_word;
                                n_st.live_stride  = i_item.data_word;
                            end
                            3'd2: begin
                                n_st.inner_left   = i_item.data_word[15:0];
                                n_st.outer_left   = i_item.data_word[31:16];
                                n_st.inner_reload = i_item.data_word[15:0];
                            end
                            3'd3: n_st.desc_ostride = i_item.data_word;
                            3'd4: n_st.src_ptr = i_item.data_word;
                            default: n_st.dst_ptr = i_item.data_word;
                        endcase
                        if (i_state.fetch_word_index >= tdcd_pkg::DESC_LAST) begin
                            n_st.fetch_busy       = 1'b0;
                            n_st.fetch_word_index = '0;
                            n_st.chan = n_st.cfg_word[tdcd_pkg::CFG_MASTER]
                                      ? tdcd_pkg::CH_ACTIVE : tdcd_pkg::CH_SLAVE;
                        end else begin
                            n_st.fetch_word_index = i_state.fetch_word_index + 3'd1;
                        end
                    end
                end
            end
            // Unknown command: no effect.
            default: ;
        endcase
        n_res.chan_status = tdcd_pkg::status_code(n_st.chan);
    end

    assign o_state  = n_st;
    assign o_result = n_res;

endmodule

`default_nettype wire

>>> sv/two_d_chained_dma_channel_unit.sv
// One channel of a two-dimensional chained descriptor DMA controller.
// Input items are register writes, engine ticks and descriptor words; each
// yields exactly one result item (copy request, fetch request, interrupts,
// status). Item flow on both sides uses valid and stall; an item moves on a
// rising edge with valid high and stall low.
// An accepted item sits in the input register until the result register is
// free or draining, is then executed against the channel state and lands in
// the result register, from which its result is offered.
// Throughput is one item per cycle unless the receiver stalls: the execute
// step is one pass of short logic with two 32-bit address adders, and the
// channel state is updated in the same edge that loads the result register.
// When the receiver stalls, the result register holds its item and the
// input register fills; the input side then stalls until the result moves.
// Synchronous active-low reset returns the channel to idle with all
// pointers, counts, strides and the config word cleared, and empties
// both registers.
// Depends on tdcd_pkg, tdcd_in_stage and tdcd_exec.
`timescale 1ns / 1ps
`default_nettype none

module two_d_chained_dma_channel_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire tdcd_pkg::t_in_item i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tdcd_pkg::t_out_item     o_out
);

    logic                q_valid;
    tdcd_pkg::t_in_item  q_item;
    logic                w_take;
    tdcd_pkg::t_state    r_state;
    tdcd_pkg::t_state    n_state;
    tdcd_pkg::t_out_item n_result;
    logic                r_out_valid;
    tdcd_pkg::t_out_item r_out;

    // Input register.
    tdcd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in),
        .i_take  (w_take),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Execute the held item when the result register is free or draining.
    assign w_take = q_valid && (!r_out_valid || !i_out_stall);

    tdcd_exec u_exec (
        .i_item   (q_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Channel state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdcd_pkg::reset_state();
        end else if (w_take) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

>>> dv/two_d_chained_dma_channel_unit_tb.sv
// Self-checking testbench for the two-dimensional chained DMA channel unit.
// Drives register writes, engine ticks and descriptor words, predicts each result
// item with a shadow of the channel, and compares field by field. Needs tdcd_pkg.
`timescale 1ns / 1ps

module two_d_chained_dma_channel_unit_tb;

    // Codes that the package does not name.
    localparam logic [1:0]  CMD_NONE    = 2'd3;
    localparam logic [2:0]  REG_AUTO0   = 3'd5;
    localparam logic [2:0]  REG_AUTO1   = 3'd6;
    localparam logic [2:0]  REG_STATUS  = 3'd7;
    localparam logic [31:0] REMOTE_BASE = 32'h0010_0000;
    localparam int          WATCHDOG    = 2000;
    localparam int          RANDOM_ITEMS = 1800;

    // Shadow copy of the channel registers.
    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] cfg;
        logic [31:0] stride_live;
        logic [15:0] inner_cnt;
        logic [15:0] outer_cnt;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] auto0;
        logic [31:0] auto1;
        logic [15:0] desc_ptr;
        logic [31:0] row_step;
        logic [31:0] plane_step;
        logic [15:0] inner_reload;
        logic        busy;
        logic [2:0]  word_idx;
        logic [15:0] fetch_ptr;
    } t_dma_shadow;

    // One entry of the stimulus queue: an item, or a pause until all results are back.
    typedef struct {
        tdcd_pkg::t_in_item item;
        int                 gap;
        bit                 drain;
    } t_bus_job;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    tdcd_pkg::t_in_item  in_item = '0;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    tdcd_pkg::t_out_item out_item;

    t_bus_job            bus_items[$];
    tdcd_pkg::t_out_item due_results[$];
    t_dma_shadow         chan_plan = '0;
    t_dma_shadow         chan_model = '0;

    int n_accepted = 0;
    int n_results = 0;
    int errors = 0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;
    bit drv_done = 1'b0;
    bit sender_calm = 1'b0;
    int n_copies = 0;
    int n_fetches = 0;
    int n_irqs = 0;
    int n_msgs = 0;

    two_d_chained_dma_channel_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    always #5 i_clk = ~i_clk;

    // Any fault in the channel is terminal: error state, fetch abandoned.
    task automatic halt_channel(inout t_dma_shadow m);
        m.status = tdcd_pkg::STAT_ERROR;
        m.busy = 1'b0;
        m.word_idx = 3'd0;
    endtask

    // Request the descriptor named by the next pointer, if it is aligned.
    task automatic begin_fetch(inout t_dma_shadow m, inout tdcd_pkg::t_out_item r);
        logic [15:0] p;
        p = m.cfg[31:16];
        if (p[2:0] != 3'd0) begin
            halt_channel(m);
        end else begin
            m.busy = 1'b1;
            m.word_idx = 3'd0;
            m.fetch_ptr = p;
            r.fetch_valid = 1'b1;
            r.fetch_addr = p;
        end
    endtask

    // Advance the shadow by one input item and give the result it causes.
    task automatic predict_channel(inout t_dma_shadow m, input tdcd_pkg::t_in_item it,
                                   output tdcd_pkg::t_out_item r);
        logic [31:0] src_step;
        logic [31:0] dst_step;
        logic        sh_src;
        logic        sh_dst;
        r = '0;
        case (it.cmd)
            tdcd_pkg::CMD_WRITE: begin
                case (it.reg_index)
                    tdcd_pkg::REG_CONFIG: begin
                        if (m.status != tdcd_pkg::STAT_IDLE) begin
                            halt_channel(m);
                        end else begin
                            m.cfg = it.data_word;
                            if (it.data_word[tdcd_pkg::CFG_DMAEN]
                                || it.data_word[tdcd_pkg::CFG_STARTUP]) begin
                                m.status = tdcd_pkg::STAT_ACTIVE;
                            end
                        end
                    end
                    tdcd_pkg::REG_STRIDE: m.stride_live = it.data_word;
                    tdcd_pkg::REG_COUNT: begin
                        m.inner_cnt = it.data_word[15:0];
                        m.outer_cnt = it.data_word[31:16];
                    end
                    tdcd_pkg::REG_SRC: m.src = it.data_word;
                    tdcd_pkg::REG_DST: m.dst = it.data_word;
                    REG_AUTO0: m.auto0 = it.data_word;
                    REG_AUTO1: m.auto1 = it.data_word;
                    default: ;
                endcase
            end
            tdcd_pkg::CMD_TICK: begin
                if (!m.busy && (m.status == tdcd_pkg::STAT_ACTIVE
                                || m.status == tdcd_pkg::STAT_SLAVE)) begin
                    if (!m.cfg[tdcd_pkg::CFG_DMAEN] && !m.cfg[tdcd_pkg::CFG_STARTUP]) begin
                        halt_channel(m);
                    end else if (m.cfg[tdcd_pkg::CFG_STARTUP]) begin
                        begin_fetch(m, r);
                    end else if (!m.cfg[tdcd_pkg::CFG_MASTER]
                                 || m.status != tdcd_pkg::STAT_ACTIVE) begin
                        halt_channel(m);
                    end else if (m.outer_cnt == 16'd0) begin
                        // Transfer done: interrupts, then stop or chain.
                        r.local_irq = m.cfg[tdcd_pkg::CFG_IRQEN];
                        if (m.cfg[tdcd_pkg::CFG_MSGMODE] && m.dst >= REMOTE_BASE) begin
                            r.msg_valid = 1'b1;
                            r.msg_core = m.dst[31:20];
                        end
                        if (!m.cfg[tdcd_pkg::CFG_CHAIN]) begin
                            m.status = tdcd_pkg::STAT_IDLE;
                        end else begin
                            begin_fetch(m, r);
                        end
                    end else if (m.inner_cnt == 16'd0) begin
                        halt_channel(m);
                    end else begin
                        // One element copy, then step over the inner or outer loop.
                        r.xfer_valid = 1'b1;
                        r.xfer_src = m.src;
                        r.xfer_dst = m.dst;
                        r.xfer_bytes = 4'd1 << m.cfg[6:5];
                        m.inner_cnt = m.inner_cnt - 16'd1;
                        if (m.inner_cnt != 16'd0) begin
                            m.stride_live = m.row_step;
                            sh_src = m.cfg[tdcd_pkg::CFG_SRC_INNER];
                            sh_dst = m.cfg[tdcd_pkg::CFG_DST_INNER];
                        end else begin
                            m.outer_cnt = m.outer_cnt - 16'd1;
                            m.inner_cnt = m.inner_reload;
                            m.stride_live = m.plane_step;
                            sh_src = m.cfg[tdcd_pkg::CFG_SRC_OUTER];
                            sh_dst = m.cfg[tdcd_pkg::CFG_DST_OUTER];
                        end
                        src_step = {{16{m.stride_live[15]}}, m.stride_live[15:0]};
                        dst_step = {{16{m.stride_live[31]}}, m.stride_live[31:16]};
                        if (sh_src) src_step = src_step << 16;
                        if (sh_dst) dst_step = dst_step << 16;
                        m.src = m.src + src_step;
                        m.dst = m.dst + dst_step;
                    end
                end
            end
            tdcd_pkg::CMD_WORD: begin
                if (m.busy) begin
                    if (it.fetch_fault) begin
                        halt_channel(m);
                    end else begin
                        case (m.word_idx)
                            3'd0: m.cfg = it.data_word;
                            3'd1: begin
                                m.row_step = it.data_word;
                                m.stride_live = it.data_word;
                            end
                            3'd2: begin
                                m.inner_cnt = it.data_word[15:0];
                                m.outer_cnt = it.data_word[31:16];
                                m.inner_reload = it.data_word[15:0];
                            end
                            3'd3: m.plane_step = it.data_word;
                            3'd4: m.src = it.data_word;
                            default: m.dst = it.data_word;
                        endcase
                        if (m.word_idx >= tdcd_pkg::DESC_LAST) begin
                            m.busy = 1'b0;
                            m.word_idx = 3'd0;
                            m.desc_ptr = m.fetch_ptr;
                            m.status = m.cfg[tdcd_pkg::CFG_MASTER]
                                     ? tdcd_pkg::STAT_ACTIVE : tdcd_pkg::STAT_SLAVE;
                        end else begin
                            m.word_idx = m.word_idx + 3'd1;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.chan_status = m.status;
    endtask

    // Queue one item and track its effect on the planning shadow.
    task automatic send(input logic [1:0] cmd, input logic [2:0] idx,
                        input logic [31:0] data, input logic fault);
        t_bus_job            job;
        tdcd_pkg::t_out_item unused;
        job.item.cmd = cmd;
        job.item.reg_index = idx;
        job.item.data_word = data;
        job.item.fetch_fault = fault;
        job.drain = 1'b0;
        if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
        job.gap = sender_calm ? 0 : $urandom_range(0, 11);
        predict_channel(chan_plan, job.item, unused);
        bus_items.push_back(job);
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic send_drain();
        t_bus_job job;
        job.item = '0;
        job.gap = 0;
        job.drain = 1'b1;
        bus_items.push_back(job);
    endtask

    // Tick with random don't-care fields.
    task automatic send_tick();
        send(tdcd_pkg::CMD_TICK, 3'($urandom), $urandom, 1'($urandom));
    endtask

    // Config word with chosen control bits, random rest, aligned next pointer.
    function automatic logic [31:0] make_cfg(input logic en, input logic mst,
                                            input logic chain, input logic start);
        logic [31:0] c;
        c = $urandom;
        c[tdcd_pkg::CFG_DMAEN] = en;
        c[tdcd_pkg::CFG_MASTER] = mst;
        c[tdcd_pkg::CFG_CHAIN] = chain;
        c[tdcd_pkg::CFG_STARTUP] = start;
        c[18:16] = 3'b000;
        return c;
    endfunction

    // Config of a chained descriptor; only the last one ends the chain.
    function automatic logic [31:0] desc_cfg(input logic last);
        logic start;
        start = !last && ($urandom_range(0, 3) == 0);
        return make_cfg(1'b1, start ? 1'($urandom_range(0, 1)) : 1'b1, !last, start);
    endfunction

    // Small loop counts keep transfers short; an empty loop now and then.
    function automatic logic [31:0] rand_count();
        if ($urandom_range(0, 7) == 0) return 32'd0;
        return {16'($urandom_range(0, 3)), 16'($urandom_range(1, 3))};
    endfunction

    // Destination mostly in remote core space, sometimes below it.
    function automatic logic [31:0] rand_dst();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 32'h000F_FFFF);
        return $urandom | REMOTE_BASE;
    endfunction

    // Deliver the six descriptor words, with the odd ignored tick in between.
    task automatic send_desc(input logic [31:0] cfg, input logic [31:0] istr,
                             input logic [31:0] cnt, input logic [31:0] ostr,
                             input logic [31:0] src, input logic [31:0] dst);
        logic [31:0] words [0:5];
        words[0] = cfg;
        words[1] = istr;
        words[2] = cnt;
        words[3] = ostr;
        words[4] = src;
        words[5] = dst;
        for (int k = 0; k < 6; k++) begin
            if ($urandom_range(0, 9) == 0) send_tick();
            send(tdcd_pkg::CMD_WORD, 3'($urandom), words[k], 1'b0);
        end
    endtask

    task automatic rand_desc(input logic [31:0] cfg);
        send_desc(cfg, $urandom, rand_count(), $urandom, $urandom, rand_dst());
    endtask

    // Items that leave a well-formed transfer on its course.
    task automatic noise_safe();
        case ($urandom_range(0, 4))
            0: send(tdcd_pkg::CMD_WRITE, 3'($urandom_range(REG_AUTO0, REG_STATUS)),
                    $urandom, 1'($urandom));
            1: send(CMD_NONE, 3'($urandom), $urandom, 1'($urandom));
            2: if (!chan_plan.busy) send(tdcd_pkg::CMD_WORD, 3'($urandom), $urandom,
                                         1'($urandom));
            3: send(tdcd_pkg::CMD_WRITE,
                    $urandom_range(0, 1) ? tdcd_pkg::REG_SRC : tdcd_pkg::REG_STRIDE,
                    $urandom, 1'($urandom));
            default: send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_DST, rand_dst(), 1'($urandom));
        endcase
    endtask

    // Tick the channel until it is idle again, feeding descriptors on request.
    task automatic run_out(input int max_links);
        int links;
        int guard;
        links = 0;
        guard = 0;
        while (chan_plan.status != tdcd_pkg::STAT_IDLE
               && chan_plan.status != tdcd_pkg::STAT_ERROR && guard < 400) begin
            guard++;
            if (chan_plan.busy) begin
                rand_desc(desc_cfg(links >= max_links));
                links++;
            end else begin
                if ($urandom_range(0, 9) == 0) noise_safe();
                send_tick();
            end
        end
    endtask

    // Transfer set up through the bus registers.
    task automatic reg_transfer();
        logic [15:0] outer;
        send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_STRIDE, $urandom, 1'($urandom));
        send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_SRC, $urandom, 1'($urandom));
        send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_DST, rand_dst(), 1'($urandom));
        // Without a known reload count the outer loop may run only once.
        outer = (chan_plan.inner_reload != 16'd0) ? 16'($urandom_range(0, 3))
                                                  : 16'($urandom_range(0, 1));
        send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_COUNT, {outer, 16'($urandom_range(1, 4))},
             1'($urandom));
        send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_CONFIG,
             make_cfg(1'b1, 1'b1, 1'($urandom_range(0, 1)), 1'b0), 1'b0);
        run_out($urandom_range(0, 3));
    endtask

    // Transfer that starts with a descriptor fetch.
    task automatic startup_transfer();
        send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_CONFIG,
             make_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b1),
             1'b0);
        run_out($urandom_range(0, 3));
    endtask

    // Drive the error into the channel by one of its routes, then prove it sticks.
    task automatic inject_error();
        logic [31:0] c;
        case ($urandom_range(0, 6))
            0: begin
                // Config write while a descriptor fetch is under way.
                send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_CONFIG,
                     make_cfg(1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b1), 1'b0);
                send_tick();
                send(tdcd_pkg::CMD_WORD, 3'($urandom), $urandom, 1'b0);
                send(tdcd_pkg::CMD_WORD, 3'($urandom), $urandom, 1'b0);
                send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_CONFIG, $urandom, 1'b0);
                for (int k = 0; k < 4; k++) begin
                    send(tdcd_pkg::CMD_WORD, 3'($urandom), $urandom, 1'b0);
                end
            end
            1: begin
                // Misaligned chain pointer on the finishing tick; interrupts still go out.
                c = make_cfg(1'b1, 1'b1, 1'b1, 1'b0);
                c[tdcd_pkg::CFG_IRQEN] = 1'b1;
                c[tdcd_pkg::CFG_MSGMODE] = 1'b1;
                c[18:16] = 3'($urandom_range(1, 7));
                send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_DST, 32'h0040_0000, 1'b0);
                send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_COUNT, 32'h0000_0003, 1'b0);
                send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_CONFIG, c, 1'b0);
                send_tick();
            end
            2: begin
                // Zero inner count with outer work left.
                send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_COUNT, 32'h0001_0000, 1'b0);
                send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_CONFIG,
                     make_cfg(1'b1, 1'b1, 1'b0, 1'b0), 1'b0);
                send_tick();
            end
            3: begin
                // Descriptor without master leaves the channel in slave state.
                send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_CONFIG,
                     make_cfg(1'b1, 1'b1, 1'b0, 1'b1), 1'b0);
                send_tick();
                rand_desc(make_cfg(1'b1, 1'b0, 1'b0, 1'b0));
                send_tick();
            end
            4: begin
                // Enabled but not master.
                send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_COUNT, rand_count(), 1'b0);
                send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_CONFIG,
                     make_cfg(1'b1, 1'b0, 1'b0, 1'b0), 1'b0);
                send_tick();
            end
            5: begin
                // Memory fault on a descriptor word.
                send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_CONFIG,
                     make_cfg(1'b0, 1'b1, 1'b0, 1'b1), 1'b0);
                send_tick();
                repeat ($urandom_range(0, 5)) begin
                    send(tdcd_pkg::CMD_WORD, 3'($urandom), $urandom, 1'b0);
                end
                send(tdcd_pkg::CMD_WORD, 3'($urandom), $urandom, 1'b1);
            end
            default: begin
                // Descriptor with neither enable nor startup, then a tick.
                send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_CONFIG,
                     make_cfg(1'b0, 1'b1, 1'b0, 1'b1), 1'b0);
                send_tick();
                rand_desc(make_cfg(1'b0, 1'b1, 1'b0, 1'b0));
                send_tick();
            end
        endcase
        repeat (16) send(2'($urandom_range(0, 3)), 3'($urandom), $urandom, 1'($urandom));
    endtask

    // Compare one result field and report a difference.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Sender: issue queued items after their gaps; hold at pause markers.
    always @(negedge i_clk) begin : drive_items
        t_bus_job head;
        int       n_issued;
        int       hold_cnt;
        if (i_rst_n && !(in_valid && n_accepted != n_issued)) begin
            if (bus_items.size() == 0) begin
                in_valid <= 1'b0;
                drv_done <= 1'b1;
            end else if (bus_items[0].drain) begin
                in_valid <= 1'b0;
                if (n_results == n_accepted) head = bus_items.pop_front();
            end else if (hold_cnt < bus_items[0].gap) begin
                in_valid <= 1'b0;
                hold_cnt++;
            end else begin
                head = bus_items.pop_front();
                hold_cnt = 0;
                n_issued++;
                in_item <= head.item;
                in_valid <= 1'b1;
            end
        end
    end

    // Receiver: stall for a random count after each accepted result.
    always @(negedge i_clk) begin : drive_stall
        int seen_results;
        int stall_left;
        bit stall_calm;
        if (n_results != seen_results) begin
            seen_results = n_results;
            if ($urandom_range(0, 49) == 0) stall_calm = !stall_calm;
            stall_left = stall_calm ? 0 : $urandom_range(0, 11);
        end
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: check each result against the oldest prediction, predict each
    // accepted item, and watch for a stuck channel.
    always @(posedge i_clk) begin : watch_items
        tdcd_pkg::t_out_item want;
        if (i_rst_n) begin
            idle_cycles++;
            if (out_valid && !out_stall) begin
                idle_cycles = 0;
                n_results++;
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             out_item);
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    check_field("xfer_valid", want.xfer_valid, out_item.xfer_valid);
                    check_field("xfer_src", want.xfer_src, out_item.xfer_src);
                    check_field("xfer_dst", want.xfer_dst, out_item.xfer_dst);
                    check_field("xfer_bytes", want.xfer_bytes, out_item.xfer_bytes);
                    check_field("fetch_valid", want.fetch_valid, out_item.fetch_valid);
                    check_field("fetch_addr", want.fetch_addr, out_item.fetch_addr);
                    check_field("local_irq", want.local_irq, out_item.local_irq);
                    check_field("msg_valid", want.msg_valid, out_item.msg_valid);
                    check_field("msg_core", want.msg_core, out_item.msg_core);
                    check_field("chan_status", want.chan_status, out_item.chan_status);
                    n_copies += want.xfer_valid;
                    n_fetches += want.fetch_valid;
                    n_irqs += want.local_irq;
                    n_msgs += want.msg_valid;
                end
            end
            if (in_valid && !in_stall) begin
                idle_cycles = 0;
                predict_channel(chan_model, in_item, want);
                due_results.push_back(want);
                n_accepted++;
            end
            if (idle_cycles >= WATCHDOG) timed_out = 1'b1;
        end
    end

    initial begin
        // Directed: ignored items and extreme register values while idle.
        send(CMD_NONE, 3'd7, 32'hFFFF_FFFF, 1'b1);
        send(tdcd_pkg::CMD_WORD, 3'd0, 32'hFFFF_FFFF, 1'b1);
        send(tdcd_pkg::CMD_TICK, 3'd0, 32'h0000_0000, 1'b0);
        send(tdcd_pkg::CMD_WRITE, REG_STATUS, 32'hFFFF_FFFF, 1'b0);
        send(tdcd_pkg::CMD_WRITE, REG_AUTO0, 32'hFFFF_FFFF, 1'b1);
        send(tdcd_pkg::CMD_WRITE, REG_AUTO1, 32'h0000_0000, 1'b0);
        send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_COUNT, 32'hFFFF_FFFF, 1'b0);
        send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_CONFIG, 32'hFFFF_FFF6, 1'b0);
        // Register transfer with widest elements, destination just below remote space.
        send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_STRIDE, 32'hFFFF_FFFF, 1'b0);
        send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_SRC, 32'hFFFF_FFFF, 1'b0);
        send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_DST, 32'h000F_FFFF, 1'b0);
        send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_COUNT, 32'h0001_0002, 1'b0);
        send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_CONFIG, 32'h0000_0473, 1'b0);
        run_out(0);
        // Startup fetch at the top descriptor address, extreme strides, all shifts.
        send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_CONFIG, {16'hFFF8, 16'h000A}, 1'b0);
        send(tdcd_pkg::CMD_TICK, 3'd0, 32'h0, 1'b0);
        send_desc(32'h0000_F417, 32'h7FFF_8000, 32'h0002_0002, 32'h8000_7FFF,
                  32'h0000_0000, REMOTE_BASE);
        run_out(1);
        send_drain();

        // Random: mostly well-formed transfers, some idle noise.
        while (bus_items.size() < RANDOM_ITEMS
               && chan_plan.status != tdcd_pkg::STAT_ERROR) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: reg_transfer();
                4, 5, 6, 7: startup_transfer();
                8: begin
                    repeat ($urandom_range(1, 4)) noise_safe();
                    send_tick();
                    send(tdcd_pkg::CMD_WRITE, tdcd_pkg::REG_CONFIG,
                         make_cfg(1'b0, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 1'b0), 1'b0);
                end
                default: send_drain();
            endcase
        end
        inject_error();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (timed_out || (drv_done && n_results == n_accepted));
        if (!timed_out) repeat (8) @(posedge i_clk);
        if (timed_out) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     n_accepted - n_results);
        end else if (n_results != n_accepted) begin
            $display("%0t: %0d expected results never arrived", $time, n_accepted - n_results);
            errors++;
        end
        $display("Covered %0d items: %0d copies, %0d descriptor fetches, %0d local irqs,",
                 n_accepted, n_copies, n_fetches, n_irqs);
        $display("%0d messages, ending in status %0d; %0d mismatches.",
                 n_msgs, chan_model.status, errors);
        if (!timed_out && errors == 0) begin
            $display("two_d_chained_dma_channel_unit_tb: PASS");
        end else begin
            $display("two_d_chained_dma_channel_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> two_d_chained_dma_channel_unit.f
sv/tdcd_pkg.sv
sv/tdcd_in_stage.sv
sv/tdcd_exec.sv
sv/two_d_chained_dma_channel_unit.sv
dv/two_d_chained_dma_channel_unit_tb.sv
